### design/aspsp_pkg.sv
// ----------------------------------------------------------------------------
// aspsp_pkg
// Shared types and constants for the AS_PATH segment parser.
// ----------------------------------------------------------------------------
package aspsp_pkg;

  localparam logic [7:0]  KIND_SET        = 8'd1;
  localparam logic [7:0]  KIND_CONFED_SET = 8'd4;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic        asn_valid;
    logic [31:0] as_number;
    logic [7:0]  segment_kind;
    logic        segment_done;
    logic        path_end;
    logic [15:0] path_count;
    logic        truncated;
  } out_beat_t;

  function automatic logic is_set_kind(input logic [7:0] kind);
    return (kind == KIND_SET) || (kind == KIND_CONFED_SET);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
    return (cnt == COUNT_MAX) ? cnt : cnt + 16'd1;
  endfunction

endpackage

### design/aspsp_parse.sv
// ----------------------------------------------------------------------------
// aspsp_parse
// Per-byte parse state and the single-pass update that produces at most one
// result for each accepted byte.
// ----------------------------------------------------------------------------
module aspsp_parse
  import aspsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      step,
  input  in_beat_t  beat,
  output logic      res_valid,
  output out_beat_t res
);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_MEMB = 2'd2
  } phase_t;

  logic        four_byte_r;
  phase_t      phase_r,   phase_nxt;
  logic [7:0]  kind_r,    kind_nxt;
  logic [7:0]  left_r,    left_nxt;
  logic [1:0]  idx_r,     idx_nxt;
  logic [31:0] acc_r,     acc_nxt;
  logic [15:0] count_r,   count_nxt;

  logic        asn_done;
  logic        seg_done;
  logic [31:0] acc_shift;
  logic [7:0]  left_dec;

  assign acc_shift = {acc_r[23:0], beat.data_byte};
  assign left_dec  = left_r - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    asn_done  = 1'b0;
    seg_done  = 1'b0;
    unique case (phase_r)
      PH_LEN: begin
        left_nxt  = beat.data_byte;
        idx_nxt   = 2'd0;
        acc_nxt   = 32'd0;
        if (is_set_kind(kind_r)) begin
          count_nxt = sat_inc(count_r);
        end
        phase_nxt = (beat.data_byte != 8'd0) ? PH_MEMB : PH_TYPE;
      end
      PH_MEMB: begin
        // A mode change mid-number takes effect on the byte where it is seen.
        asn_done = four_byte_r ? (idx_r == 2'd3) : (idx_r != 2'd0);
        if (asn_done) begin
          left_nxt = left_dec;
          seg_done = (left_dec == 8'd0);
          if (!is_set_kind(kind_r)) begin
            count_nxt = sat_inc(count_r);
          end
          acc_nxt = 32'd0;
          idx_nxt = 2'd0;
          if (seg_done) begin
            phase_nxt = PH_TYPE;
          end
        end else begin
          acc_nxt = acc_shift;
          idx_nxt = idx_r + 2'd1;
        end
      end
      default: begin
        kind_nxt  = beat.data_byte;
        phase_nxt = PH_LEN;
      end
    endcase
  end

  always_comb begin
    res_valid        = asn_done || beat.final_byte;
    res.asn_valid    = asn_done;
    res.as_number    = asn_done ? acc_shift : 32'd0;
    res.segment_kind = asn_done ? kind_r : 8'd0;
    res.segment_done = seg_done;
    res.path_end     = beat.final_byte;
    res.path_count   = count_nxt;
    res.truncated    = beat.final_byte && (phase_nxt != PH_TYPE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_byte_r <= 1'b0;
      phase_r     <= PH_TYPE;
      kind_r      <= 8'd0;
      left_r      <= 8'd0;
      idx_r       <= 2'd0;
      acc_r       <= 32'd0;
      count_r     <= 16'd0;
    end else begin
      if (cfg_we) begin
        four_byte_r <= cfg_wdata;
      end
      if (step) begin
        // The final byte returns all parse state to its reset value.
        if (beat.final_byte) begin
          phase_r <= PH_TYPE;
          kind_r  <= 8'd0;
          left_r  <= 8'd0;
          idx_r   <= 2'd0;
          acc_r   <= 32'd0;
          count_r <= 16'd0;
        end else begin
          phase_r <= phase_nxt;
          kind_r  <= kind_nxt;
          left_r  <= left_nxt;
          idx_r   <= idx_nxt;
          acc_r   <= acc_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end

endmodule

### design/aspsp_skid.sv
// ----------------------------------------------------------------------------
// aspsp_skid
// Two-entry result buffer that keeps the input side moving while a result
// beat waits for the consumer.
// ----------------------------------------------------------------------------
module aspsp_skid
  import aspsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_beat_t push_data,
  output logic      has_room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  out_beat_t   head_r, head_nxt;
  out_beat_t   tail_r, tail_nxt;
  logic [1:0]  cnt_r,  cnt_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign has_room  = (cnt_r != 2'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          tail_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

### design/as_path_segment_parser_top.sv
// ----------------------------------------------------------------------------
// as_path_segment_parser_top
// AS_PATH attribute parser: one value byte per beat in, AS numbers with their
// segment type and the running path length out.
// ----------------------------------------------------------------------------
// Each result beat is registered in the result buffer before it is offered.
// Throughput: one byte per cycle while the buffer has room; the parse state
// updates in a single pass. The two-entry buffer lets input continue while
// a result waits. Reset (synchronous, rst_n low) clears the parse state, the
// count, the mode register (2-byte AS numbers) and the result buffer.
module as_path_segment_parser_top
  import aspsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      step;
  logic      res_valid;
  out_beat_t res;
  logic      has_room;

  assign in_ready = has_room;
  assign step     = in_valid && in_ready;

  aspsp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .beat      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  aspsp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
